FILE: rtl/ordered_list_with_middle_ops_macros.svh
// Assertion macros for the file that checks the list logic.
// Each macro takes a label, the clock, the active-low reset, a condition,
// an implied condition and a message.
`ifndef ORDERED_LIST_WITH_MIDDLE_OPS_MACROS_SVH
`define ORDERED_LIST_WITH_MIDDLE_OPS_MACROS_SVH
`ifndef SYNTH
// The implied condition must hold in the same cycle.
`define OLMO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The implied condition must hold in the next cycle.
`define OLMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OLMO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define OLMO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/olmo_pkg.sv
`default_nettype none

package olmo_pkg;

    // Operation codes carried in the func field of a request.
    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_MID   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_MID   = 3'd5,
        FN_RD_FWD    = 3'd6,
        FN_RD_BWD    = 3'd7
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Where an insert or delete acts.
    typedef enum logic [1:0] {
        POS_FRONT = 2'd0,
        POS_BACK  = 2'd1,
        POS_MID   = 2'd2
    } pos_sel_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } olmo_state_t;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     do_ins;
        logic     do_del;
        pos_sel_t pos_sel;
        logic     rd_start;
        logic     rd_back;
        logic     rd_step;
        logic     load_rsp;
        logic     rsp_read;
        logic     rsp_last;
        status_t  rsp_status;
    } olmo_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic rd_last;
        logic rsp_busy;
    } olmo_stat_t;

endpackage

`default_nettype wire

FILE: rtl/olmo_req_if.sv
`default_nettype none

// Request channel: one operation and its value.
interface olmo_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic signed [31:0] value_in;

    modport source (output valid, output func, output value_in, input ready);
    modport sink (input valid, input func, input value_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/olmo_rsp_if.sv
`default_nettype none

// Result channel: one result item per transfer.
interface olmo_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               last;

    modport source (output valid, output value_out, output status, output entry_count,
                    output last, input ready);
    modport sink (input valid, input value_out, input status, input entry_count,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/olmo_ctrl.sv
`default_nettype none

module olmo_ctrl
    import olmo_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire func_t      req_func,
    output logic            req_ready,
    input  wire olmo_stat_t st,
    output olmo_cmd_t       cmd
);

    olmo_state_t state_reg;
    olmo_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        cmd            = '0;
        cmd.pos_sel    = POS_FRONT;
        cmd.rsp_status = STAT_OK;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = !st.rsp_busy;
                if (req_valid && !st.rsp_busy)
                begin
                    cmd.load_rsp = 1'b1;
                    cmd.rsp_last = 1'b1;
                    unique case (req_func)
                        FN_INS_FRONT, FN_INS_BACK, FN_INS_MID:
                        begin
                            if (st.full)
                            begin
                                cmd.rsp_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.do_ins = 1'b1;
                                cmd.pos_sel = (req_func == FN_INS_FRONT) ? POS_FRONT :
                                              (req_func == FN_INS_BACK)  ? POS_BACK  :
                                                                           POS_MID;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_MID:
                        begin
                            if (st.empty)
                            begin
                                cmd.rsp_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.do_del = 1'b1;
                                cmd.pos_sel = (req_func == FN_DEL_FRONT) ? POS_FRONT :
                                              (req_func == FN_DEL_BACK)  ? POS_BACK  :
                                                                           POS_MID;
                            end
                        end
                        FN_RD_FWD, FN_RD_BWD:
                        begin
                            if (st.empty)
                            begin
                                cmd.rsp_status = STAT_EMPTY;
                            end
                            else
                            begin
                                // The elements go out from the read state.
                                cmd.load_rsp = 1'b0;
                                cmd.rsp_last = 1'b0;
                                cmd.rd_start = 1'b1;
                                cmd.rd_back  = (req_func == FN_RD_BWD);
                                state_next   = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // One element per cycle while the result register is free.
                if (!st.rsp_busy)
                begin
                    cmd.load_rsp = 1'b1;
                    cmd.rsp_read = 1'b1;
                    cmd.rsp_last = st.rd_last;
                    cmd.rd_step  = 1'b1;
                    if (st.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/olmo_datapath.sv
`default_nettype none

module olmo_datapath
    import olmo_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire olmo_cmd_t                 cmd,
    input  wire logic signed [VALUE_W-1:0] value_in,
    output olmo_stat_t                     st,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    output logic signed [VALUE_W-1:0]      value_out,
    output logic [1:0]                     status,
    output logic [COUNT_W-1:0]             entry_count,
    output logic                           last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] cells_reg [CAPACITY];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             pos;
    logic [IW-1:0]             rd_cnt_reg;
    logic [IW-1:0]             rd_cnt_next;
    logic                      rd_back_reg;
    logic                      rd_back_next;
    logic [IW-1:0]             rd_idx;
    logic signed [VALUE_W-1:0] rd_data;
    logic [CW+COUNT_W-1:0]     count_ext;

    logic                      rsp_valid_reg;
    logic signed [VALUE_W-1:0] value_out_reg;
    logic [1:0]                status_reg;
    logic [COUNT_W-1:0]        entry_count_reg;
    logic                      last_reg;

    // Position of the insert or delete.
    always_comb
    begin
        unique case (cmd.pos_sel)
            POS_FRONT: pos = '0;
            POS_BACK:  pos = cmd.do_ins ? count_reg : count_reg - CW'(1);
            POS_MID:   pos = cmd.do_ins ? ((count_reg + CW'(1)) >> 1) : (count_reg >> 1);
            default:   pos = '0;
        endcase
    end

    // Each cell keeps its value, takes the new one, or shifts from a neighbor.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [VALUE_W-1:0] from_prev;
        logic signed [VALUE_W-1:0] from_next;
        logic signed [VALUE_W-1:0] cell_next;

        if (k == 0)
        begin : g_first
            assign from_prev = value_in;
        end
        else
        begin : g_prev
            assign from_prev = cells_reg[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_final
            assign from_next = cells_reg[k];
        end
        else
        begin : g_next
            assign from_next = cells_reg[k+1];
        end

        always_comb
        begin
            cell_next = cells_reg[k];
            if (cmd.do_ins)
            begin
                if (CW'(k) == pos)
                begin
                    cell_next = value_in;
                end
                else if (CW'(k) > pos)
                begin
                    cell_next = from_prev;
                end
            end
            else if (cmd.do_del && (CW'(k) >= pos))
            begin
                cell_next = from_next;
            end
        end

        always_ff @(posedge clk)
        begin
            cells_reg[k] <= cell_next;
        end
    end

    // Occupancy after the operation.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.do_del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Read walk: counter of emitted elements and direction.
    always_comb
    begin
        rd_cnt_next  = rd_cnt_reg;
        rd_back_next = rd_back_reg;
        if (cmd.rd_start)
        begin
            rd_cnt_next  = '0;
            rd_back_next = cmd.rd_back;
        end
        else if (cmd.rd_step)
        begin
            rd_cnt_next = rd_cnt_reg + IW'(1);
        end
    end

    assign rd_idx  = rd_back_reg ? IW'(count_reg - CW'(1) - CW'(rd_cnt_reg)) : rd_cnt_reg;
    assign rd_data = cells_reg[rd_idx];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            rd_back_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_back_reg <= rd_back_next;
            if (cmd.load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The reported count keeps its low five bits.
    assign count_ext = (CW + COUNT_W)'(count_next);

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            value_out_reg   <= cmd.rsp_read ? rd_data : '0;
            status_reg      <= cmd.rsp_status;
            entry_count_reg <= count_ext[COUNT_W-1:0];
            last_reg        <= cmd.rsp_last;
        end
    end

    assign st.empty    = (count_reg == '0);
    assign st.full     = (count_reg == CW'(CAPACITY));
    assign st.rd_last  = (CW'(rd_cnt_reg) == count_reg - CW'(1));
    assign st.rsp_busy = rsp_valid_reg && !rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign value_out   = value_out_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

FILE: rtl/ordered_list_with_middle_ops.sv
// Channel | Direction | Payload                               | Handshake
// req     | in        | func, value_in                        | valid / ready
// rsp     | out       | value_out, status, entry_count, last  | valid / ready
//
// Inserts, deletes and rejected or empty operations each give a single result.
// A read of n elements first enters the read state, then gives one result per cycle while no result stalls.
// The result register sets the pace: a stalled result holds off new requests.
// Reset clears the count and the controller; the element cells are not reset.
`default_nettype none
`include "ordered_list_with_middle_ops_macros.svh"

module ordered_list_with_middle_ops
    import olmo_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic   clk,
    input wire logic   rst_n,
    olmo_req_if.sink   req,
    olmo_rsp_if.source rsp
);

    olmo_cmd_t  cmd;
    olmo_stat_t st;

    // Operation sequencer.
    olmo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (func_t'(req.func)),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Element cells, count and result register.
    olmo_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value_in    (req.value_in),
        .st          (st),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .value_out   (rsp.value_out),
        .status      (rsp.status),
        .entry_count (rsp.entry_count),
        .last        (rsp.last)
    );

    // A result is never loaded over one that is still waiting.
    `OLMO_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.load_rsp, !st.rsp_busy, "result overwritten")
    // Inserts only into a list with room, deletes only from a non-empty list.
    `OLMO_ASSERT_SAME(a_ins_room, clk, rst_n, cmd.do_ins, !st.full, "insert into full list")
    `OLMO_ASSERT_SAME(a_del_some, clk, rst_n, cmd.do_del, !st.empty, "delete from empty list")
    // No request is taken while a read is streaming out.
    `OLMO_ASSERT_SAME(a_no_req_in_read, clk, rst_n, cmd.rd_step, !(req.valid && req.ready),
                      "request taken during read")
    // After the final read element the read walk takes no further step.
    `OLMO_ASSERT_NEXT(a_read_end, clk, rst_n, cmd.rd_step && st.rd_last, !cmd.rd_step,
                      "read ran past the last element")

endmodule

`default_nettype wire
